[rtl/path_bounding_box_defines.svh]
// Assertion macros for the path bounding box block.
`ifndef PATH_BOUNDING_BOX_DEFINES_SVH
`define PATH_BOUNDING_BOX_DEFINES_SVH
`ifndef SYNTHESIS
`define PBB_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("path_bounding_box check failed");
`define PBB_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("path_bounding_box check failed");
`else
`define PBB_ASSERT_IMP(label, clk, rst, a, b)
`define PBB_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

[rtl/pbb_pkg.sv]
// Shared constants, types and helper functions for the path bounding box block.
package pbb_pkg;
  localparam int COORD_WIDTH  = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int XW = 33;  // CORDIC vector, Q30 with headroom
  localparam int TW = 34;  // residual binary angle
  localparam longint DEG360_Q16 = 64'd23592960;
  localparam longint DEG180_Q16 = 64'd11796480;
  localparam longint ANGLE_BIAS = 128 * DEG360_Q16;
  localparam longint GAIN_LIMIT_Q30 = 64'd652032874;
  localparam longint GAIN_EXCESS_Q30 = 64'd434688583;
  localparam longint GAIN_INIT = GAIN_LIMIT_Q30 + (GAIN_EXCESS_Q30 >> (2 * CORDIC_STEPS));
  localparam int DIV_DIGITS = 12;  // 48-bit dividend, four quotient bits a cycle
  localparam int DIV_CNT_W = $clog2(DIV_DIGITS + 1);

  // Command kinds carried on the mode field.
  typedef enum logic [1:0] {
    MODE_MOVE  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_CURVE = 2'd2,
    MODE_ARC   = 2'd3
  } mode_t;

  typedef struct packed {
    logic                 neg;
    logic                 tag;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [TW-1:0] t;
  } cordic_word_t;

  function automatic logic signed [TW-1:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051E;  5'd2: v = 32'h09FB385B;
      5'd3: v = 32'h051111D4;  5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;  5'd8: v = 32'h0028BE53;
      5'd9: v = 32'h00145F2F;  5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518; 5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146; 5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014; 5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005; 5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001; 5'd31: v = 32'h00000000;
      default: v = 32'h00000000;
    endcase
    return TW'(signed'({1'b0, v}));
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return COORD_WIDTH'(hi);
    else if (v < lo) return COORD_WIDTH'(lo);
    else return COORD_WIDTH'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return 32'(v);
  endfunction

  function automatic logic [30:0] sat_len(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 31'h7FFFFFFF;
    else if (v < 64'sd0) return 31'd0;
    else return 31'(v);
  endfunction
endpackage

[rtl/pbb_angle_div.sv]
// Degree to binary angle conversion: digit-serial divide by 45, four bits a cycle.
module pbb_angle_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] angle,
  output logic               done,
  output logic [31:0]        turn
);
  import pbb_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [47:0]          dividend;
  logic [5:0]           rem;
  logic [5:0]           rem_next;
  logic [3:0]           qdig;
  logic [34:0]          biased;

  // Offset by whole turns so the dividend is positive; the low quotient bits hold.
  assign biased = 35'(angle) + 35'(ANGLE_BIAS);

  always_comb begin
    logic [6:0] r;
    r = {1'b0, rem};
    for (int k = 0; k < 4; k++) begin
      r = {r[5:0], dividend[47 - k]};
      if (r >= 7'd45) begin
        r = r - 7'd45;
        qdig[3 - k] = 1'b1;
      end else begin
        qdig[3 - k] = 1'b0;
      end
    end
    rem_next = r[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dividend <= {2'b00, biased[32:0], 13'd0};
      end else if (busy) begin
        rem      <= rem_next;
        dividend <= {dividend[43:0], 4'd0};
        turn     <= {turn[27:0], qdig};
        cnt      <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[rtl/pbb_cordic_cell.sv]
// One CORDIC rotation cell: a registered micro-rotation by a fixed step.
module pbb_cordic_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [pbb_pkg::STEP_W-1:0] step,
  input  logic                       in_valid,
  input  pbb_pkg::cordic_word_t      in_word,
  output logic                       out_valid,
  output pbb_pkg::cordic_word_t      out_word
);
  import pbb_pkg::*;

  cordic_word_t     word_next;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [TW-1:0] at;

  assign dx = in_word.y >>> step;
  assign dy = in_word.x >>> step;
  assign at = atan_turn(5'(step));

  always_comb begin
    word_next = in_word;
    if (!in_word.t[TW-1]) begin
      word_next.x = in_word.x - dx;
      word_next.y = in_word.y + dy;
      word_next.t = in_word.t - at;
    end else begin
      word_next.x = in_word.x + dx;
      word_next.y = in_word.y - dy;
      word_next.t = in_word.t + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= in_valid;
    out_word <= word_next;
  end
endmodule

[rtl/pbb_cordic.sv]
// Row of CORDIC cells; a word advances one cell per cycle.
module pbb_cordic (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  pbb_pkg::cordic_word_t in_word,
  output logic                  out_valid,
  output pbb_pkg::cordic_word_t out_word
);
  import pbb_pkg::*;

  logic         v [CORDIC_STEPS+1];
  cordic_word_t w [CORDIC_STEPS+1];

  assign v[0] = in_valid;
  assign w[0] = in_word;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    pbb_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step     (STEP_W'(i)),
      .in_valid (v[i]),
      .in_word  (w[i]),
      .out_valid(v[i+1]),
      .out_word (w[i+1])
    );
  end

  assign out_valid = v[CORDIC_STEPS];
  assign out_word  = w[CORDIC_STEPS];
endmodule

[rtl/path_bounding_box.sv]
// Top level: running bounding box of a vector path, one command word at a time.
//
// Input channel (in_valid/in_ready): one path command word per handshake:
// mode (move, line, curve, arc), operands x1, y1, x2, y2 and last.
// Output channel (out_valid/out_ready): one box word (rect_x, rect_y,
// rect_width, rect_height) for every command word marked last.
// Steps: move, line and curve update the state at the edge after acceptance;
// an arc runs the degree to binary angle divide (four quotient bits a
// cycle), a step to pick up its done, the row of CORDIC cells (both angles
// follow each other down the row), the shared radius multiplier, then the
// update. A last word then passes through a load step for the result.
// One command word is in flight at a time; in_ready is high when the block
// is idle, also while a finished box still waits on the output register.
// If the receiver stalls and a second last word finishes, the block holds in
// its load step until the output register is free.
// Reset clears the path (next word seeds the box), the pen and out_valid.
module path_bounding_box (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic signed [31:0] x1,
  input  logic signed [31:0] y1,
  input  logic signed [31:0] x2,
  input  logic signed [31:0] y2,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] rect_x,
  output logic signed [31:0] rect_y,
  output logic [30:0] rect_width,
  output logic [30:0] rect_height
);
  import pbb_pkg::*;
`include "path_bounding_box_defines.svh"

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_FEED0, ST_FEED1, ST_CWAIT, ST_MUL, ST_APPLY, ST_EMIT
  } state_t;

  state_t state;

  // Held command word.
  logic [1:0]                    cmd_mode;
  logic                          cmd_last;
  logic signed [31:0]            radius;
  logic signed [COORD_WIDTH-1:0] pa, pb, pc, pd;

  // Box, pen and path state.
  logic signed [COORD_WIDTH-1:0] min_x, min_y, max_x, max_y;
  logic signed [COORD_WIDTH-1:0] pen_x, pen_y;
  logic                          path_start;

  // Angle dividers.
  logic        div_start;
  logic        div_done_b, div_done_e;
  logic [31:0] turn_b, turn_e;

  // CORDIC row.
  logic         cor_in_valid;
  cordic_word_t cor_in;
  logic         cor_out_valid;
  cordic_word_t cor_out;
  logic signed [XW-1:0] cos_b, sin_b, cos_e, sin_e;

  // Radius multiplier and arc geometry.
  logic [2:0]                    mcnt;
  logic signed [XW-1:0]          mul_f;
  logic signed [XW+31:0]         prod;
  logic signed [XW+31:0]         prod_rnd;
  logic signed [63:0]            scaled;
  logic signed [COORD_WIDTH-1:0] cx, cy, ax, ay;

  assign in_ready  = (state == ST_IDLE);
  assign div_start = in_valid && in_ready && (mode == MODE_ARC);

  pbb_angle_div u_div_begin (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .angle(33'(y1) + 33'(DEG180_Q16)),
    .done (div_done_b),
    .turn (turn_b)
  );

  pbb_angle_div u_div_end (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .angle(33'(x2)),
    .done (div_done_e),
    .turn (turn_e)
  );

  // Fold the angle into [-90, 90] degrees; a fold negates both results.
  always_comb begin
    logic signed [TW-1:0] t;
    t = TW'(signed'(state == ST_FEED0 ? turn_b : turn_e));
    cor_in.x   = XW'(GAIN_INIT);
    cor_in.y   = '0;
    cor_in.tag = (state == ST_FEED1);
    cor_in.neg = 1'b0;
    if (t > (TW'(1) <<< 30)) begin
      cor_in.t   = t - (TW'(1) <<< 31);
      cor_in.neg = 1'b1;
    end else if (t < -(TW'(1) <<< 30)) begin
      cor_in.t   = t + (TW'(1) <<< 31);
      cor_in.neg = 1'b1;
    end else begin
      cor_in.t = t;
    end
  end

  assign cor_in_valid = (state == ST_FEED0) || (state == ST_FEED1);

  pbb_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cor_in_valid),
    .in_word  (cor_in),
    .out_valid(cor_out_valid),
    .out_word (cor_out)
  );

  // Pick the multiplier operand: begin cos, begin sin, end cos, end sin.
  always_comb begin
    unique case (mcnt[1:0])
      2'd0: mul_f = cos_b;
      2'd1: mul_f = sin_b;
      2'd2: mul_f = cos_e;
      2'd3: mul_f = sin_e;
      default: mul_f = cos_b;
    endcase
  end

  // Round Q19.46 product to nearest, half up, back to Q16.16.
  assign prod_rnd = prod + ((XW+32)'(1) <<< 29);
  assign scaled   = 64'(prod_rnd >>> 30);

  // Next box from the held word; the first word of a path seeds it.
  logic signed [COORD_WIDTH-1:0] nmin_x, nmin_y, nmax_x, nmax_y;
  logic signed [COORD_WIDTH-1:0] p1x, p1y, p2x, p2y;
  always_comb begin
    nmin_x = path_start ? pa : min_x;
    nmax_x = path_start ? pa : max_x;
    nmin_y = path_start ? pb : min_y;
    nmax_y = path_start ? pb : max_y;
    if (cmd_mode == MODE_ARC) begin
      p1x = ax; p1y = ay;
    end else begin
      p1x = pa; p1y = pb;
    end
    p2x = (cmd_mode == MODE_CURVE) ? pc : p1x;
    p2y = (cmd_mode == MODE_CURVE) ? pd : p1y;
    if (p1x < nmin_x) nmin_x = p1x;
    if (p1x > nmax_x) nmax_x = p1x;
    if (p1y < nmin_y) nmin_y = p1y;
    if (p1y > nmax_y) nmax_y = p1y;
    if (p2x < nmin_x) nmin_x = p2x;
    if (p2x > nmax_x) nmax_x = p2x;
    if (p2y < nmin_y) nmin_y = p2y;
    if (p2y > nmax_y) nmax_y = p2y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      path_start <= 1'b1;
      pen_x      <= '0;
      pen_y      <= '0;
      mcnt       <= '0;
    end else begin
      // Drop the box once taken; the load step refills the register itself.
      if (out_valid && out_ready && state != ST_EMIT) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_mode <= mode;
            cmd_last <= last;
            radius   <= x1;
            pa       <= sat_coord(64'(x1));
            pb       <= sat_coord(64'(y1));
            pc       <= sat_coord(64'(x2));
            pd       <= sat_coord(64'(y2));
            state    <= (mode == MODE_ARC) ? ST_DIV : ST_APPLY;
          end
        end
        ST_DIV: begin
          if (div_done_b) state <= ST_FEED0;
        end
        ST_FEED0: state <= ST_FEED1;
        ST_FEED1: state <= ST_CWAIT;
        ST_CWAIT: begin
          // Capture each angle as it leaves the row.
          if (cor_out_valid) begin
            if (!cor_out.tag) begin
              cos_b <= cor_out.neg ? -cor_out.x : cor_out.x;
              sin_b <= cor_out.neg ? -cor_out.y : cor_out.y;
            end else begin
              cos_e <= cor_out.neg ? -cor_out.x : cor_out.x;
              sin_e <= cor_out.neg ? -cor_out.y : cor_out.y;
              mcnt  <= '0;
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          // Issue one product a cycle, consume the previous one.
          prod <= (XW+32)'(radius) * (XW+32)'(mul_f);
          mcnt <= mcnt + 1'b1;
          unique case (mcnt)
            3'd1: cx <= sat_coord(64'(pen_x) + scaled);
            3'd2: cy <= sat_coord(64'(pen_y) + scaled);
            3'd3: ax <= sat_coord(64'(cx) + scaled);
            3'd4: begin
              ay    <= sat_coord(64'(cy) + scaled);
              state <= ST_APPLY;
            end
            default: ;
          endcase
        end
        ST_APPLY: begin
          min_x      <= nmin_x;
          min_y      <= nmin_y;
          max_x      <= nmax_x;
          max_y      <= nmax_y;
          path_start <= 1'b0;
          pen_x      <= p2x;
          pen_y      <= p2y;
          state      <= cmd_last ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          // Hold until the output register is free.
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            rect_x      <= sat32(64'(min_x));
            rect_y      <= sat32(64'(min_y));
            rect_width  <= sat_len(64'(max_x) - 64'(min_x));
            rect_height <= sat_len(64'(max_y) - 64'(min_y));
            pen_x       <= '0;
            pen_y       <= '0;
            path_start  <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `PBB_ASSERT_IMP(a_div_done_in_div, clk, rst, div_done_b, state == ST_DIV && div_done_e)
  `PBB_ASSERT_IMP(a_cordic_out_in_wait, clk, rst, cor_out_valid, state == ST_CWAIT)
  `PBB_ASSERT_NEXT(a_emit_loads, clk, rst, state == ST_EMIT && (!out_valid || out_ready), out_valid && path_start && state == ST_IDLE)
  `PBB_ASSERT_NEXT(a_short_cmd, clk, rst, in_valid && in_ready && mode != MODE_ARC, state == ST_APPLY)
endmodule
